// ===== rtl/adq_pkg.sv =====
// adq_pkg: shared types and constants for the array deque engine
// used by adq_ctrl, adq_dp and array_deque_engine; no dependencies
package adq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    FN_PUSH_REAR  = 3'd0,
    FN_POP_FRONT  = 3'd1,
    FN_PEEK_FRONT = 3'd2,
    FN_PUSH_FRONT = 3'd3,
    FN_POP_REAR   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_result;
  } cmd_t;

endpackage

// ===== rtl/adq_ram.sv =====
// adq_ram: generic single write port, single read port ram with registered read
// no dependencies
module adq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/adq_dp.sv =====
// adq_dp: deque datapath with indices, empty flag, slot ram and result register
// depends on adq_pkg and adq_ram
module adq_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  adq_pkg::cmd_t              cmd,
  input  logic [2:0]                 func,
  input  logic signed [31:0]         push_value,
  output logic signed [31:0]         read_value,
  output logic [1:0]                 status
);

  localparam adq_pkg::idx_t LAST = adq_pkg::IDX_W'(adq_pkg::DEPTH - 1);
  localparam adq_pkg::idx_t ZERO = '0;
  localparam adq_pkg::idx_t ONE  = adq_pkg::IDX_W'(1);

  adq_pkg::idx_t front_index, front_index_next;
  adq_pkg::idx_t rear_index, rear_index_next;
  logic is_empty, is_empty_next;

  logic                   op_we, op_re;
  adq_pkg::idx_t          op_waddr, op_raddr;
  adq_pkg::status_t       op_status_next;
  logic                   op_read_next;

  adq_pkg::status_t       op_status;
  logic                   op_read;
  logic [adq_pkg::DATA_W-1:0] ram_q;

  always_comb begin
    op_we            = 1'b0;
    op_re            = 1'b0;
    op_waddr         = front_index;
    op_raddr         = front_index;
    front_index_next = front_index;
    rear_index_next  = rear_index;
    is_empty_next    = is_empty;
    op_status_next   = adq_pkg::ST_OK;
    op_read_next     = 1'b0;
    unique case (func)
      adq_pkg::FN_PUSH_REAR: begin
        if (is_empty) begin
          op_we = 1'b1; op_waddr = ZERO;
          front_index_next = ZERO; rear_index_next = ZERO; is_empty_next = 1'b0;
        end else if (rear_index == LAST) begin
          op_status_next = adq_pkg::ST_FULL;
        end else begin
          op_we = 1'b1; op_waddr = rear_index + ONE;
          rear_index_next = rear_index + ONE;
        end
      end
      adq_pkg::FN_POP_FRONT: begin
        if (is_empty) begin
          op_status_next = adq_pkg::ST_EMPTY;
        end else begin
          op_re = 1'b1; op_raddr = front_index; op_read_next = 1'b1;
          if (front_index == rear_index) begin
            front_index_next = ZERO; rear_index_next = ZERO; is_empty_next = 1'b1;
          end else begin
            front_index_next = front_index + ONE;
          end
        end
      end
      adq_pkg::FN_PEEK_FRONT: begin
        if (is_empty) begin
          op_status_next = adq_pkg::ST_EMPTY;
        end else begin
          op_re = 1'b1; op_raddr = front_index; op_read_next = 1'b1;
        end
      end
      adq_pkg::FN_PUSH_FRONT: begin
        if (is_empty) begin
          op_we = 1'b1; op_waddr = ZERO;
          front_index_next = ZERO; rear_index_next = ZERO; is_empty_next = 1'b0;
        end else if (front_index == ZERO) begin
          op_status_next = adq_pkg::ST_FULL;
        end else begin
          op_we = 1'b1; op_waddr = front_index - ONE;
          front_index_next = front_index - ONE;
        end
      end
      adq_pkg::FN_POP_REAR: begin
        if (is_empty) begin
          op_status_next = adq_pkg::ST_EMPTY;
        end else begin
          op_re = 1'b1; op_raddr = rear_index; op_read_next = 1'b1;
          if (front_index == rear_index) begin
            front_index_next = ZERO; rear_index_next = ZERO; is_empty_next = 1'b1;
          end else begin
            rear_index_next = rear_index - ONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  adq_ram #(
    .WIDTH(adq_pkg::DATA_W),
    .DEPTH(adq_pkg::DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.accept & op_we),
    .waddr(op_waddr),
    .wdata($unsigned(push_value)),
    .re   (cmd.accept & op_re),
    .raddr(op_raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= ZERO;
      rear_index  <= ZERO;
      is_empty    <= 1'b1;
    end else if (cmd.accept) begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      is_empty    <= is_empty_next;
    end
  end

  // operation outcome held until the ram read data is back
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_status <= op_status_next;
      op_read   <= op_read_next;
    end
    if (cmd.load_result) begin
      read_value <= op_read ? $signed(ram_q) : 32'sd0;
      status     <= op_status;
    end
  end

endmodule

// ===== rtl/adq_ctrl.sv =====
// adq_ctrl: handshake controller state machine and output valid register
// depends on adq_pkg
module adq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output adq_pkg::cmd_t cmd
);

  adq_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      adq_pkg::S_IDLE: if (in_valid) state_next = adq_pkg::S_EXEC;
      adq_pkg::S_EXEC: if (out_free) state_next = adq_pkg::S_IDLE;
      default:         state_next = adq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cmd.accept      = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state)
      adq_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      adq_pkg::S_EXEC: cmd.load_result = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == adq_pkg::S_EXEC)
    else $error("accepted transfer did not enter execute");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> out_valid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.load_result)
    else $error("stalled result overwritten");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.load_result))
    else $error("accept and result load in the same cycle");

endmodule

// ===== rtl/array_deque_engine.sv =====
// array_deque_engine: linear array deque, one result per operation
// result path: the ram read is registered, then the result register drives read_value and out_valid
// a new operation is not taken until the current result has been loaded into the result register
// a stalled result holds the engine in execute until it is taken
// reset clears indices, sets the empty flag and drops out_valid; slots are not cleared
module array_deque_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [1:0]         status
);

  adq_pkg::cmd_t cmd;

  adq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  adq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (func),
    .push_value(push_value),
    .read_value(read_value),
    .status    (status)
  );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for array_deque_engine, driven over valid/stall on both sides
// depends on adq_pkg and the array_deque_engine rtl; a deque_checker class tracks the
// expected deque contents and matches every result against the oldest prediction

localparam logic [2:0] FN_FIRST_UNUSED = 3'(adq_pkg::FN_POP_REAR) + 3'd1;
localparam logic [2:0] FN_LAST_CODE = '1;

typedef struct packed {
  logic [adq_pkg::DATA_W-1:0] value;
  adq_pkg::status_t           status;
} deque_result_t;

class deque_checker;
  logic [adq_pkg::DATA_W-1:0] slot_mem [adq_pkg::DEPTH];
  adq_pkg::idx_t              head_idx;
  adq_pkg::idx_t              tail_idx;
  bit                         empty;
  deque_result_t              owed_results [$];
  int                         mismatches;

  function new();
    head_idx = '0;
    tail_idx = '0;
    empty = 1'b1;
    mismatches = 0;
  endfunction

  function void place_first(logic [adq_pkg::DATA_W-1:0] val);
    head_idx = '0;
    tail_idx = '0;
    empty = 1'b0;
    slot_mem[0] = val;
  endfunction

  function void make_empty();
    head_idx = '0;
    tail_idx = '0;
    empty = 1'b1;
  endfunction

  function void note_input(logic [2:0] op, logic [adq_pkg::DATA_W-1:0] val);
    deque_result_t r;
    r.value = '0;
    r.status = adq_pkg::ST_OK;
    case (op)
      adq_pkg::FN_PUSH_REAR: begin
        if (empty) begin
          place_first(val);
        end else if (tail_idx == adq_pkg::idx_t'(adq_pkg::DEPTH - 1)) begin
          r.status = adq_pkg::ST_FULL;
        end else begin
          tail_idx++;
          slot_mem[tail_idx] = val;
        end
      end
      adq_pkg::FN_POP_FRONT: begin
        if (empty) begin
          r.status = adq_pkg::ST_EMPTY;
        end else begin
          r.value = slot_mem[head_idx];
          if (head_idx == tail_idx) make_empty();
          else head_idx++;
        end
      end
      adq_pkg::FN_PEEK_FRONT: begin
        if (empty) r.status = adq_pkg::ST_EMPTY;
        else r.value = slot_mem[head_idx];
      end
      adq_pkg::FN_PUSH_FRONT: begin
        if (empty) begin
          place_first(val);
        end else if (head_idx == '0) begin
          r.status = adq_pkg::ST_FULL;
        end else begin
          head_idx--;
          slot_mem[head_idx] = val;
        end
      end
      adq_pkg::FN_POP_REAR: begin
        if (empty) begin
          r.status = adq_pkg::ST_EMPTY;
        end else begin
          r.value = slot_mem[tail_idx];
          if (head_idx == tail_idx) make_empty();
          else tail_idx--;
        end
      end
      default: ;
    endcase
    owed_results.push_back(r);
  endfunction

  function void check_result(logic [adq_pkg::DATA_W-1:0] got_value, logic [1:0] got_status);
    deque_result_t want;
    if (owed_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: read_value %h status %0d", got_value, got_status);
      return;
    end
    want = owed_results.pop_front();
    if (got_value !== want.value || got_status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: read_value exp %h got %h, status exp %0d got %0d",
                 want.value, got_value, want.status, got_status);
    end
  endfunction
endclass

module tb;
  localparam int HOLD_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         func = '0;
  logic signed [31:0] push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic [1:0]         status;

  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  bit hold_out = 1'b0;

  deque_checker sb;

  array_deque_engine uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(logic [2:0] op, logic [31:0] val);
    while (!in_quiet && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    push_value <= val;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, val);
  endtask

  // stop offering, then wait until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed_results.size() != 0);
  endtask

  // result transfer check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(read_value, status);
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !out_quiet && ($urandom_range(0, 99) < 14);
      end
    end
  end

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int         r;
    int         push_pct;
    logic [2:0] op;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty-queue reads, single-element pushes and pops from both ends
    send_op(adq_pkg::FN_POP_FRONT, $urandom);
    send_op(adq_pkg::FN_POP_REAR, $urandom);
    send_op(adq_pkg::FN_PEEK_FRONT, $urandom);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h7fff_ffff);
    send_op(adq_pkg::FN_POP_REAR, $urandom);
    send_op(adq_pkg::FN_PUSH_FRONT, 32'h8000_0000);
    send_op(adq_pkg::FN_PUSH_FRONT, 32'h1111_1111);
    send_op(adq_pkg::FN_POP_FRONT, $urandom);
    // fill from the rear up to the last slot, then overflow
    send_op(adq_pkg::FN_PUSH_REAR, 32'hffff_ffff);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h0000_0000);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h0000_0001);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h5555_5555);
    send_op(adq_pkg::FN_PUSH_REAR, 32'haaaa_aaaa);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h7fff_ffff);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h8000_0000);
    send_op(adq_pkg::FN_PUSH_REAR, 32'h1234_5678);
    send_op(adq_pkg::FN_PUSH_REAR, 32'hdead_beef);
    send_op(adq_pkg::FN_PEEK_FRONT, $urandom);
    send_op(adq_pkg::FN_POP_FRONT, $urandom);
    send_op(adq_pkg::FN_PUSH_FRONT, 32'hcafe_f00d);
    // unused codes
    send_op(FN_FIRST_UNUSED, 32'hffff_ffff);
    send_op(FN_FIRST_UNUSED + 3'd1, $urandom);
    send_op(FN_LAST_CODE, 32'hffff_ffff);
    send_op(adq_pkg::FN_POP_REAR, $urandom);
    send_op(adq_pkg::FN_POP_FRONT, $urandom);

    for (int seg = 0; seg < 13; seg++) begin
      if (seg == 3) begin
        // long receiver hold while the sender keeps offering
        hold_out = 1'b1;
        in_quiet = 1'b1;
        repeat (16)
          send_op(3'($urandom_range(adq_pkg::FN_PUSH_REAR, adq_pkg::FN_POP_REAR)),
                  pick_value());
        in_quiet = 1'b0;
        wait_drained();
      end
      in_quiet = (seg == 6);
      out_quiet = (seg == 6);
      case ($urandom_range(0, 2))
        0: push_pct = 70;
        1: push_pct = 45;
        default: push_pct = 25;
      endcase
      repeat (50) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          op = r[0] ? adq_pkg::FN_PUSH_REAR : adq_pkg::FN_PUSH_FRONT;
        end else if (r < push_pct + 4) begin
          op = 3'($urandom_range(FN_FIRST_UNUSED, FN_LAST_CODE));
        end else begin
          case ($urandom_range(0, 2))
            0: op = adq_pkg::FN_POP_FRONT;
            1: op = adq_pkg::FN_POP_REAR;
            default: op = adq_pkg::FN_PEEK_FRONT;
          endcase
        end
        send_op(op, pick_value());
      end
    end
    in_quiet = 1'b0;
    out_quiet = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== array_deque_engine.f =====
rtl/adq_pkg.sv
rtl/adq_ram.sv
rtl/adq_dp.sv
rtl/adq_ctrl.sv
rtl/array_deque_engine.sv
tb/tb.sv
